// File: rtl/ppmd_pkg.sv
// ppmd_pkg: shared types and constants of the ppm frame decoder
// used by every module of the block; depends on nothing

package ppmd_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int MIN_CHANNELS = 4;

    localparam int TIME_W  = 32;
    localparam int US_W    = 16;
    localparam int OUT_W   = 12;
    localparam int STAB_W  = 8;
    localparam int CH_W    = 4;
    localparam int POS_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // position value stored when no count is known
    localparam logic [POS_W-1:0] NONE_MARK = 5'd31;

    // product of offset and output span, and the quotient steps it needs
    localparam int PROD_W    = US_W + OUT_W;
    localparam int DIV_STEPS = OUT_W;
    localparam int STEP_W    = 4;

    // channel command queue
    localparam int QDEPTH = 4;
    localparam int Q_AW   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_MIN     = 3'd0,
        CFG_CHANNEL_MIN  = 3'd1,
        CFG_CHANNEL_MAX  = 3'd2,
        CFG_MAP_IN_LOW   = 3'd3,
        CFG_MAP_IN_HIGH  = 3'd4,
        CFG_OUT_LOW      = 3'd5,
        CFG_OUT_HIGH     = 3'd6,
        CFG_STABLE       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [US_W-1:0]   sync_min_us;
        logic [US_W-1:0]   channel_min_us;
        logic [US_W-1:0]   channel_max_us;
        logic [US_W-1:0]   map_in_low;
        logic [US_W-1:0]   map_in_high;
        logic [OUT_W-1:0]  out_low;
        logic [OUT_W-1:0]  out_high;
        logic [STAB_W-1:0] stable_needed;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0] index;
        logic [US_W-1:0] width;
        logic            valid;
        logic            last;
    } t_chan_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// File: rtl/ppm_frame_decoder_core.sv
// ppm_frame_decoder_core: top level of the ppm frame decoder, holding the
// configuration registers; depends on ppmd_pkg, ppmd_front, ppmd_fifo, ppmd_map

// Accepts one rising-edge timestamp per input word and reports decoded frames
// as sixteen channel words, index 0 to 15, the last one flagged. An edge that
// does not close an emitted frame leaves input ready high. An edge that closes
// a frame while the channel count is locked starts a sweep that queues one
// command per channel; input ready stays low until all sixteen are queued. The
// back end takes each in-range channel word through one multiply, a 12-step
// serial divider, an offset add and the output load; a clamped or unused
// channel skips the divider. The user must write configuration through the
// plain write port only while idle; the block itself does not enforce it.

module ppm_frame_decoder_core import ppmd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [TIME_W-1:0]     i_edge_time,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CH_W-1:0]       o_channel_index,
    output logic [OUT_W-1:0]      o_channel_value,
    output logic                  o_channel_valid,
    output logic                  o_frame_last
);

    t_cfg       r_cfg;
    logic       w_push, w_pop;
    t_chan_cmd  w_cmd, w_head;
    t_fifo_stat w_fifo_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_min_us    <= 16'd2700;
            r_cfg.channel_min_us <= 16'd750;
            r_cfg.channel_max_us <= 16'd2500;
            r_cfg.map_in_low     <= 16'd1000;
            r_cfg.map_in_high    <= 16'd2000;
            r_cfg.out_low        <= 12'd1000;
            r_cfg.out_high       <= 12'd2000;
            r_cfg.stable_needed  <= 8'd25;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SYNC_MIN:    r_cfg.sync_min_us    <= i_cfg_data;
                CFG_CHANNEL_MIN: r_cfg.channel_min_us <= i_cfg_data;
                CFG_CHANNEL_MAX: r_cfg.channel_max_us <= i_cfg_data;
                CFG_MAP_IN_LOW:  r_cfg.map_in_low     <= i_cfg_data;
                CFG_MAP_IN_HIGH: r_cfg.map_in_high    <= i_cfg_data;
                CFG_OUT_LOW:     r_cfg.out_low        <= i_cfg_data[OUT_W-1:0];
                CFG_OUT_HIGH:    r_cfg.out_high       <= i_cfg_data[OUT_W-1:0];
                CFG_STABLE:      r_cfg.stable_needed  <= i_cfg_data[STAB_W-1:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    ppmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_edge_time (i_edge_time),
        .o_push      (w_push),
        .o_cmd       (w_cmd),
        .i_fifo_stat (w_fifo_stat)
    );

    ppmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_fifo_stat)
    );

    ppmd_map u_map (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head          (w_head),
        .i_fifo_stat     (w_fifo_stat),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_channel_valid (o_channel_valid),
        .o_frame_last    (o_frame_last)
    );

    // queue never written when full, never read when empty
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_stat.full)
        else $error("channel queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_stat.empty)
        else $error("channel queue popped while empty");

    // unused channel words carry a zero value
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_channel_valid) |-> (o_channel_value == '0))
        else $error("invalid channel word with nonzero value");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_last) |-> (o_channel_index == CH_W'(MAX_CHANNELS - 1)))
        else $error("frame end flagged on wrong channel");

endmodule

// File: rtl/ppmd_front.sv
// ppmd_front: edge interval classification, frame tracking, width store
// and per-channel command sweep; depends on ppmd_pkg

module ppmd_front import ppmd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [TIME_W-1:0] i_edge_time,
    output logic              o_push,
    output t_chan_cmd         o_cmd,
    input  t_fifo_stat        i_fifo_stat
);

    typedef enum logic [1:0] {
        FS_IDLE = 2'b01,
        FS_EMIT = 2'b10
    } t_front_state;

    t_front_state r_state, n_state;
    logic [TIME_W-1:0] r_prev, n_prev;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_locked, n_locked;
    logic [POS_W-1:0]  r_prior, n_prior;
    logic [STAB_W-1:0] r_stable, n_stable;
    logic              r_in_sync, n_in_sync;
    logic [CH_W-1:0]   r_k, n_k;
    logic [US_W-1:0]   r_store [MAX_CHANNELS];

    logic              w_accept;
    logic [TIME_W-1:0] w_interval;
    logic              w_is_sync;
    logic              w_stable_cond;
    logic              w_chan_ok;
    logic              w_store_we;
    logic              w_last_k;

    assign o_ready    = (r_state == FS_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_interval = i_edge_time - r_prev;
    assign w_is_sync  = w_interval > TIME_W'(i_cfg.sync_min_us);
    assign w_stable_cond = (r_pos == r_prior) && (r_pos >= POS_W'(MIN_CHANNELS))
                        && (r_pos <= POS_W'(MAX_CHANNELS));
    assign w_chan_ok  = (w_interval > TIME_W'(i_cfg.channel_min_us))
                     && (w_interval < TIME_W'(i_cfg.channel_max_us))
                     && (r_pos < POS_W'(MAX_CHANNELS));
    assign w_last_k   = (r_k == CH_W'(MAX_CHANNELS - 1));

    assign o_push       = (r_state == FS_EMIT) && !i_fifo_stat.full;
    assign o_cmd.index  = r_k;
    assign o_cmd.width  = r_store[r_k];
    assign o_cmd.valid  = ({1'b0, r_k} < r_locked);
    assign o_cmd.last   = w_last_k;

    always_comb begin
        n_state   = r_state;
        n_prev    = r_prev;
        n_pos     = r_pos;
        n_locked  = r_locked;
        n_prior   = r_prior;
        n_stable  = r_stable;
        n_in_sync = r_in_sync;
        n_k       = r_k;
        w_store_we = 1'b0;
        case (r_state)
            FS_IDLE: begin
                if (w_accept) begin
                    n_prev = i_edge_time;
                    if (w_interval != '0) begin
                        if (w_is_sync) begin
                            if (w_stable_cond) begin
                                if (r_stable < i_cfg.stable_needed) begin
                                    n_stable = r_stable + STAB_W'(1);
                                end else begin
                                    n_locked = r_pos;
                                end
                            end else begin
                                n_stable = '0;
                            end
                            // the lock may take effect on this very frame
                            if (r_in_sync && (r_pos == n_locked)) begin
                                n_state = FS_EMIT;
                                n_k     = '0;
                            end
                            n_in_sync = 1'b1;
                            n_prior   = r_pos;
                            n_pos     = '0;
                        end else if (r_in_sync) begin
                            if (w_chan_ok) begin
                                w_store_we = 1'b1;
                                n_pos      = r_pos + POS_W'(1);
                            end else begin
                                n_in_sync = 1'b0;
                            end
                        end
                    end
                end
            end
            FS_EMIT: begin
                if (o_push) begin
                    n_k = r_k + CH_W'(1);
                    if (w_last_k) begin
                        n_state = FS_IDLE;
                    end
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FS_IDLE;
            r_prev    <= '0;
            r_pos     <= '0;
            r_locked  <= NONE_MARK;
            r_prior   <= NONE_MARK;
            r_stable  <= '0;
            r_in_sync <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_prev    <= n_prev;
            r_pos     <= n_pos;
            r_locked  <= n_locked;
            r_prior   <= n_prior;
            r_stable  <= n_stable;
            r_in_sync <= n_in_sync;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_pos[CH_W-1:0]] <= w_interval[US_W-1:0];
        end
    end

endmodule

// File: rtl/ppmd_fifo.sv
// ppmd_fifo: short queue of channel commands between front and back
// depends on ppmd_pkg

module ppmd_fifo import ppmd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_chan_cmd  i_cmd,
    input  logic       i_pop,
    output t_chan_cmd  o_head,
    output t_fifo_stat o_stat
);

    t_chan_cmd       r_mem [QDEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == (Q_AW+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// File: rtl/ppmd_map.sv
// ppmd_map: clamps and maps one channel width per command, with a
// bit-serial divider and the result output register; depends on ppmd_pkg

module ppmd_map import ppmd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_chan_cmd        i_head,
    input  t_fifo_stat       i_fifo_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CH_W-1:0]  o_channel_index,
    output logic [OUT_W-1:0] o_channel_value,
    output logic             o_channel_valid,
    output logic             o_frame_last
);

    typedef enum logic [4:0] {
        BS_IDLE = 5'b00001,
        BS_CALC = 5'b00010,
        BS_DIV  = 5'b00100,
        BS_FIN  = 5'b01000,
        BS_DONE = 5'b10000
    } t_back_state;

    t_back_state       r_state;
    t_chan_cmd         r_cmd;
    logic [OUT_W-1:0]  r_res;
    logic              r_neg;
    logic [US_W-1:0]   r_span;
    logic [US_W-1:0]   r_rem;
    logic [OUT_W-1:0]  r_numlo;
    logic [OUT_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_o_valid;

    logic              w_below, w_above, w_flat, w_neg;
    logic [US_W-1:0]   w_span, w_offs;
    logic [OUT_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [US_W:0]     w_rem2, w_diff;
    logic              w_ge;
    logic              w_out_free;
    logic              w_load;

    assign w_below = r_cmd.width < i_cfg.map_in_low;
    assign w_above = r_cmd.width > i_cfg.map_in_high;
    assign w_span  = i_cfg.map_in_high - i_cfg.map_in_low;
    assign w_flat  = (w_span == '0);
    assign w_neg   = i_cfg.out_high < i_cfg.out_low;
    assign w_mag   = w_neg ? (i_cfg.out_low - i_cfg.out_high)
                           : (i_cfg.out_high - i_cfg.out_low);
    assign w_offs  = r_cmd.width - i_cfg.map_in_low;
    assign w_prod  = PROD_W'(w_offs) * PROD_W'(w_mag);

    // restoring step: quotient fits the output width since offs <= span
    assign w_rem2  = {r_rem, r_numlo[OUT_W-1]};
    assign w_diff  = w_rem2 - {1'b0, r_span};
    assign w_ge    = (w_rem2 >= {1'b0, r_span});

    assign w_out_free = !r_o_valid || i_ready;
    assign w_load     = (r_state == BS_DONE) && w_out_free;
    assign o_pop      = (r_state == BS_IDLE) && !i_fifo_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                BS_IDLE: begin
                    if (o_pop) begin
                        r_state <= BS_CALC;
                    end
                end
                BS_CALC: begin
                    if (!r_cmd.valid || w_below || w_above || w_flat) begin
                        r_state <= BS_DONE;
                    end else begin
                        r_state <= BS_DIV;
                    end
                end
                BS_DIV: begin
                    if (r_step == '0) begin
                        r_state <= BS_FIN;
                    end
                end
                BS_FIN: begin
                    r_state <= BS_DONE;
                end
                BS_DONE: begin
                    if (w_out_free) begin
                        r_state <= BS_IDLE;
                    end
                end
                default: begin
                    r_state <= BS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                if (o_pop) begin
                    r_cmd <= i_head;
                end
            end
            BS_CALC: begin
                if (!r_cmd.valid) begin
                    r_res <= '0;
                end else if (w_below) begin
                    r_res <= i_cfg.out_low;
                end else if (w_above) begin
                    r_res <= i_cfg.out_high;
                end else if (w_flat) begin
                    r_res <= i_cfg.out_low;
                end
                r_neg   <= w_neg;
                r_span  <= w_span;
                r_rem   <= w_prod[PROD_W-1:OUT_W];
                r_numlo <= w_prod[OUT_W-1:0];
                r_step  <= STEP_W'(DIV_STEPS - 1);
            end
            BS_DIV: begin
                r_rem   <= w_ge ? w_diff[US_W-1:0] : w_rem2[US_W-1:0];
                r_numlo <= {r_numlo[OUT_W-2:0], 1'b0};
                r_quo   <= {r_quo[OUT_W-2:0], w_ge};
                r_step  <= r_step - STEP_W'(1);
            end
            BS_FIN: begin
                r_res <= r_neg ? (i_cfg.out_low - r_quo) : (i_cfg.out_low + r_quo);
            end
            BS_DONE: begin
                if (w_out_free) begin
                    o_channel_index <= r_cmd.index;
                    o_channel_value <= r_res;
                    o_channel_valid <= r_cmd.valid;
                    o_frame_last    <= r_cmd.last;
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_valid = r_o_valid;

endmodule

// File: dv/ppm_frame_decoder_core_test.sv
// ppm_frame_decoder_core_test: self-checking bench for the ppm frame decoder core
// drives edge timestamps, predicts the decoded channel words and compares them
// depends on ppmd_pkg and ppm_frame_decoder_core

module ppm_frame_decoder_core_test;
    import ppmd_pkg::*;

    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [CH_W-1:0]  idx;
        logic [OUT_W-1:0] value;
        logic             present;
        logic             last;
    } t_chan_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [TIME_W-1:0]     i_edge_time = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [CH_W-1:0]       o_channel_index;
    logic [OUT_W-1:0]      o_channel_value;
    logic                  o_channel_valid;
    logic                  o_frame_last;

    ppm_frame_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_edge_time     (i_edge_time),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_channel_valid (o_channel_valid),
        .o_frame_last    (o_frame_last)
    );

    always #5 i_clk = ~i_clk;

    // decoder copy kept by the bench
    t_cfg              cfg_m;
    logic [TIME_W-1:0] last_stamp;
    logic [POS_W-1:0]  chan_pos;
    logic [US_W-1:0]   pulse_widths [MAX_CHANNELS];
    logic [POS_W-1:0]  lock_cnt;
    logic [POS_W-1:0]  prev_cnt;
    logic [STAB_W-1:0] match_run;
    logic              synced;

    logic [TIME_W-1:0] stamp_q [$];
    t_chan_word        frame_words_q [$];
    logic [TIME_W-1:0] stamp = '0;

    logic word_in_taken = 1'b0;
    logic word_out_taken = 1'b0;
    logic send_busy = 1'b0;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   calm_left [2] = '{0, 0};
    int   fail_cnt = 0;
    int   edges_taken = 0;
    int   frames_out = 0;
    int   reg_writes = 0;

    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side] = calm_left[side] - 1;
            return 0;
        end
        // now and then a stretch with no idling at all
        if ($urandom_range(0, 9) == 0) begin
            calm_left[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [OUT_W-1:0] scale_width(input logic [US_W-1:0] w);
        longint lo;
        longint hi;
        longint span;
        longint v;
        lo = cfg_m.out_low;
        hi = cfg_m.out_high;
        if (w < cfg_m.map_in_low)
            return lo[OUT_W-1:0];
        if (w > cfg_m.map_in_high)
            return hi[OUT_W-1:0];
        span = longint'(cfg_m.map_in_high) - longint'(cfg_m.map_in_low);
        if (span <= 0)
            return lo[OUT_W-1:0];
        v = lo + (longint'(w) - longint'(cfg_m.map_in_low)) * (hi - lo) / span;
        return v[OUT_W-1:0];
    endfunction

    task automatic decode_edge(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] gap_us;
        t_chan_word        w;
        int                k;
        gap_us = now - last_stamp;
        last_stamp = now;
        if (gap_us != 0) begin
            if (gap_us > cfg_m.sync_min_us) begin
                if (chan_pos == prev_cnt && chan_pos >= MIN_CHANNELS
                        && chan_pos <= MAX_CHANNELS) begin
                    if (match_run < cfg_m.stable_needed)
                        match_run = match_run + 1'b1;
                    else
                        lock_cnt = chan_pos;
                end else begin
                    match_run = '0;
                end
                if (synced && chan_pos == lock_cnt) begin
                    for (k = 0; k < MAX_CHANNELS; k++) begin
                        w.idx = k[CH_W-1:0];
                        w.present = (k < lock_cnt);
                        w.value = w.present ? scale_width(pulse_widths[k]) : '0;
                        w.last = (k == MAX_CHANNELS - 1);
                        frame_words_q.push_back(w);
                    end
                    frames_out++;
                end
                synced = 1'b1;
                prev_cnt = chan_pos;
                chan_pos = '0;
            end else if (synced) begin
                if (gap_us > cfg_m.channel_min_us && gap_us < cfg_m.channel_max_us
                        && chan_pos < MAX_CHANNELS) begin
                    pulse_widths[chan_pos[CH_W-1:0]] = gap_us[US_W-1:0];
                    chan_pos = chan_pos + 1'b1;
                end else begin
                    synced = 1'b0;
                end
            end
        end
    endtask

    task automatic reset_model();
        cfg_m.sync_min_us = 2700;
        cfg_m.channel_min_us = 750;
        cfg_m.channel_max_us = 2500;
        cfg_m.map_in_low = 1000;
        cfg_m.map_in_high = 2000;
        cfg_m.out_low = 1000;
        cfg_m.out_high = 2000;
        cfg_m.stable_needed = 25;
        last_stamp = '0;
        chan_pos = '0;
        lock_cnt = NONE_MARK;
        prev_cnt = NONE_MARK;
        match_run = '0;
        synced = 1'b0;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SYNC_MIN:    cfg_m.sync_min_us = data;
            CFG_CHANNEL_MIN: cfg_m.channel_min_us = data;
            CFG_CHANNEL_MAX: cfg_m.channel_max_us = data;
            CFG_MAP_IN_LOW:  cfg_m.map_in_low = data;
            CFG_MAP_IN_HIGH: cfg_m.map_in_high = data;
            CFG_OUT_LOW:     cfg_m.out_low = data[OUT_W-1:0];
            CFG_OUT_HIGH:    cfg_m.out_high = data[OUT_W-1:0];
            CFG_STABLE:      cfg_m.stable_needed = data[STAB_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] sync_min, input logic [15:0] ch_min,
                             input logic [15:0] ch_max, input logic [15:0] in_lo,
                             input logic [15:0] in_hi, input logic [15:0] out_lo,
                             input logic [15:0] out_hi, input logic [15:0] stable);
        write_reg(CFG_SYNC_MIN, sync_min);
        write_reg(CFG_CHANNEL_MIN, ch_min);
        write_reg(CFG_CHANNEL_MAX, ch_max);
        write_reg(CFG_MAP_IN_LOW, in_lo);
        write_reg(CFG_MAP_IN_HIGH, in_hi);
        write_reg(CFG_OUT_LOW, out_lo);
        write_reg(CFG_OUT_HIGH, out_hi);
        write_reg(CFG_STABLE, stable);
    endtask

    task automatic push_gap(input logic [TIME_W-1:0] iv);
        stamp = stamp + iv;
        stamp_q.push_back(stamp);
    endtask

    task automatic push_sync();
        logic [TIME_W-1:0] gap;
        // mostly short sync gaps, sometimes a huge one that flips the high bits
        if ($urandom_range(0, 5) == 0)
            gap = 32'h8000_0000 | $urandom();
        else
            gap = cfg_m.sync_min_us + 1 + $urandom_range(0, 4000);
        push_gap(gap);
    endtask

    function automatic int pick_width();
        int lo;
        int hi;
        int w;
        lo = cfg_m.channel_min_us + 1;
        hi = cfg_m.channel_max_us;
        hi = hi - 1;
        if (hi > cfg_m.sync_min_us)
            hi = cfg_m.sync_min_us;
        case ($urandom_range(0, 7))
            0: w = lo;
            1: w = hi;
            2: w = cfg_m.map_in_low;
            3: w = cfg_m.map_in_high;
            default: w = $urandom_range(lo, hi);
        endcase
        if (w < lo || w > hi)
            w = $urandom_range(lo, hi);
        return w;
    endfunction

    task automatic push_frame(input int count);
        push_sync();
        repeat (count) push_gap(pick_width());
    endtask

    task automatic push_noise();
        case ($urandom_range(0, 3))
            0: push_gap('0);
            1: push_gap($urandom_range(0, cfg_m.channel_min_us));
            2: push_gap($urandom_range(cfg_m.channel_max_us, cfg_m.channel_max_us + 300));
            default: push_gap($urandom());
        endcase
    endtask

    task automatic run_random(input int frames, input int n);
        repeat (frames) begin
            case ($urandom_range(0, 9))
                6: push_frame($urandom_range(0, MAX_CHANNELS + 1));
                7: begin
                    // frame broken by a bad pulse somewhere inside
                    push_sync();
                    repeat ($urandom_range(0, n)) push_gap(pick_width());
                    push_noise();
                    repeat ($urandom_range(0, 3)) push_gap(pick_width());
                end
                8: repeat ($urandom_range(1, 3)) push_noise();
                9: push_frame(MAX_CHANNELS);
                default: push_frame(n);
            endcase
        end
        push_sync();
    endtask

    task automatic wait_drained();
        while (stamp_q.size() != 0 || send_busy || frame_words_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic wait_settled();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender side: one edge word at a time from the pending queue
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (word_in_taken) begin
                word_in_taken = 1'b0;
                send_busy = 1'b0;
                send_wait = draw_wait(0);
            end
            if (!send_busy) begin
                if (send_wait > 0) begin
                    send_wait = send_wait - 1;
                    i_valid <= 1'b0;
                end else if (stamp_q.size() != 0) begin
                    i_edge_time <= stamp_q.pop_front();
                    i_valid <= 1'b1;
                    send_busy = 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver side: stall after each channel word for a drawn number of cycles
    always @(negedge i_clk) begin
        if (word_out_taken) begin
            word_out_taken = 1'b0;
            recv_wait = draw_wait(1);
        end
        if (recv_wait > 0) begin
            recv_wait = recv_wait - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_chan_word w;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                decode_edge(i_edge_time);
                word_in_taken = 1'b1;
                edges_taken++;
            end
            if (o_valid && i_ready) begin
                word_out_taken = 1'b1;
                if (frame_words_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected channel word: index %0d value %0d valid %0b last %0b",
                                 o_channel_index, o_channel_value, o_channel_valid,
                                 o_frame_last);
                end else begin
                    w = frame_words_q.pop_front();
                    if (o_channel_index !== w.idx || o_channel_value !== w.value
                            || o_channel_valid !== w.present || o_frame_last !== w.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("channel word mismatch: expected index %0d value %0d valid %0b last %0b",
                                     w.idx, w.value, w.present, w.last);
                            $display("    got index %0d value %0d valid %0b last %0b",
                                     o_channel_index, o_channel_value, o_channel_valid,
                                     o_frame_last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        int n;
        reset_model();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings but an immediate lock: zero interval, all-ones stamp,
        // wrap, map and window edges
        write_reg(CFG_STABLE, 0);
        push_gap('0);
        push_gap(32'hFFFF_FFFF);
        push_gap(1000);
        push_gap(2000);
        push_gap(751);
        push_gap(2499);
        push_gap('0);
        push_gap(2701);
        push_gap(1200);
        push_gap(1500);
        push_gap(1800);
        push_gap(900);
        push_gap(2700);     // equal to the sync threshold: a bad pulse, not a sync
        push_gap(1000);
        push_gap(5000);
        push_gap(750);      // equal to the channel minimum: bad pulse
        push_gap(3000);
        repeat (2) push_frame(MIN_CHANNELS);
        push_sync();
        wait_settled();

        // reversed output range, lock on the first repeated count
        write_all(2700, 750, 2500, 1000, 2000, 4095, 0, 0);
        run_random(3, $urandom_range(MIN_CHANNELS, 5));
        wait_settled();

        // degenerate map range
        write_all(3000, 900, 2200, 1500, 1500, 0, 4095, 0);
        run_random(3, $urandom_range(MIN_CHANNELS, 5));
        wait_settled();

        // widest windows, upper data bits beyond the narrow registers
        write_all(16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF);
        n = (lock_cnt >= MIN_CHANNELS && lock_cnt <= MAX_CHANNELS) ? lock_cnt : MIN_CHANNELS;
        run_random(1, n);
        wait_settled();

        // zero sync threshold: every nonzero interval is a sync gap
        write_all(0, 16'hFFFF, 0, 16'hFFFF, 0, 0, 0, 0);
        repeat (8) push_gap($urandom());
        push_gap('0);
        push_gap(1);
        wait_settled();

        // two full frames of sixteen channels, the second one emitted
        write_all(2000, 800, 1900, 950, 2050, 100, 3900, 0);
        repeat (2) push_frame(MAX_CHANNELS);
        push_sync();
        // hold the sender until every channel word is out
        wait_drained();
        run_random(1, $urandom_range(MIN_CHANNELS, 8));
        wait_settled();

        $display("covered %0d edge words, %0d decoded frames, %0d register writes",
                 edges_taken, frames_out, reg_writes);
        $display("ranges: default, reversed and flat maps, widest and zero windows");
        if (fail_cnt == 0 && frame_words_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
